FILE: hdl/ps2_mouse_cursor_tracker_unit_macros.svh
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker assertion macros
// Concurrent assertion helpers that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_CURSOR_TRACKER_UNIT_MACROS_SVH
`define PS2_MOUSE_CURSOR_TRACKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define PS2MCT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ps2mct assertion failed");

// Next-cycle implication, checked out of reset
`define PS2MCT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ps2mct assertion failed");

`else

`define PS2MCT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PS2MCT_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: hdl/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker package
// Shared field widths, button event codes, result record and delta scaling.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

    localparam int BYTE_W  = 8;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CELL_W  = 11;
    localparam int DELTA_W = 6;
    localparam int EV_W    = 2;

    // Button transition between consecutive packets
    typedef enum logic [EV_W-1:0] {
        EV_HOVER   = 2'd0,
        EV_PRESS   = 2'd1,
        EV_DRAG    = 2'd2,
        EV_RELEASE = 2'd3
    } button_event_t;

    // One decoded packet
    typedef struct packed {
        logic                click;
        logic [CELL_W-1:0]   anchor_cell;
        button_event_t       button_event;
        logic                left_pressed;
        logic [CELL_W-1:0]   new_cell;
        logic [CELL_W-1:0]   old_cell;
        logic [ROW_W-1:0]    cursor_row;
        logic [COL_W-1:0]    cursor_col;
    } result_t;

    // Handshake between the byte register and the decoder
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } byte_item_t;

    // Signed byte divided by 4, truncated toward zero (range -32..31)
    function automatic logic signed [DELTA_W-1:0] delta_div4(input logic [BYTE_W-1:0] b);
        logic signed [BYTE_W:0] biased;
        biased = $signed({b[BYTE_W-1], b}) + $signed({7'b0, b[BYTE_W-1], b[BYTE_W-1]});
        return biased[BYTE_W-1:2];
    endfunction

endpackage

FILE: hdl/ps2_mouse_cursor_tracker_unit.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker
// Decodes three-byte mouse packets into text-grid cursor moves and clicks.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one mouse byte per item. The first byte after reset
//   is dropped; after that bytes are framed as status, X delta, Y delta.
//   m_ channel carries one item per packet, issued for its Y byte: the
//   clamped cursor, old and new cell indices, the left button bit, the
//   button event (hover, press, drag, release), the selection anchor and
//   the click flag.
//   A Y byte accepted into the input register is decoded combinationally,
//   then loaded into the result register, which drives m_tvalid.
//   Throughput: one byte per cycle while a Y byte finds room in the result
//   register; the single decode step lies between the two registers.
//   Reset (aresetn low, synchronous) empties both registers, clears the
//   cursor, anchor and button history, and re-arms the first-byte drop.
//   When the receiver stalls, the result register holds its item; status
//   and X bytes keep flowing, and a Y byte waits in the input register
//   until the result register frees up.
// ----------------------------------------------------------------------------
`include "ps2_mouse_cursor_tracker_unit_macros.svh"

module ps2_mouse_cursor_tracker_unit #(
    parameter int GRID_COLS = 80,
    parameter int GRID_ROWS = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [6:0] cursor_col, [11:7] cursor_row,
                                   // [22:12] old_cell, [33:23] new_cell,
                                   // [34] left_pressed, [36:35] button_event,
                                   // [47:37] anchor_cell, [48] click,
                                   // [55:49] zero
);

    ps2mct_pkg::byte_item_t item;
    ps2mct_pkg::result_t    res;
    ps2mct_pkg::result_t    m_res;
    logic                   take;
    logic                   res_valid;
    logic                   out_free;

    ps2mct_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .item     (item)
    );

    ps2mct_cursor_core #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (item),
        .out_free  (out_free),
        .take      (take),
        .res_valid (res_valid),
        .res       (res)
    );

    ps2mct_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    // Pack the result record, zero-filled to whole bytes
    assign m_tdata = {7'b0, m_res};

    // Cursor stays on the grid
    `PS2MCT_ASSERT_IMP(a_col_in_grid, aclk, aresetn, m_tvalid, {25'b0, m_res.cursor_col} < GRID_COLS)
    `PS2MCT_ASSERT_IMP(a_row_in_grid, aclk, aresetn, m_tvalid, {27'b0, m_res.cursor_row} < GRID_ROWS)
    // A click only comes with a release
    `PS2MCT_ASSERT_IMP(a_click_on_release, aclk, aresetn, m_tvalid && m_res.click, m_res.button_event == ps2mct_pkg::EV_RELEASE && m_res.anchor_cell == m_res.new_cell)
    // A press sets the anchor to the new cell
    `PS2MCT_ASSERT_IMP(a_press_anchor, aclk, aresetn, m_tvalid && m_res.button_event == ps2mct_pkg::EV_PRESS, m_res.anchor_cell == m_res.new_cell && m_res.left_pressed)
    // A new result is never loaded over one that is still stalled
    `PS2MCT_ASSERT_IMP(a_no_overwrite, aclk, aresetn, res_valid, !m_tvalid || m_tready)

endmodule

FILE: hdl/ps2mct_in_stage.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker input register
// Holds one received byte until the decoder takes it.
// ----------------------------------------------------------------------------
module ps2mct_in_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ps2mct_pkg::BYTE_W-1:0] s_tdata,
    input  logic                          take,
    output ps2mct_pkg::byte_item_t        item
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [ps2mct_pkg::BYTE_W-1:0] data_reg;

    // Free when empty or being drained this cycle
    assign s_tready = !valid_reg || take;

    // Load on accept, drop after the decoder takes the item
    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

FILE: hdl/ps2mct_cursor_core.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker decoder
// Packet framing, cursor move with clamping and button event classification.
// ----------------------------------------------------------------------------
module ps2mct_cursor_core #(
    parameter int GRID_COLS = 80,
    parameter int GRID_ROWS = 25
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ps2mct_pkg::byte_item_t item,
    input  logic                   out_free,
    output logic                   take,
    output logic                   res_valid,
    output ps2mct_pkg::result_t    res
);

    typedef enum logic [1:0] {
        PH_UNSYNC = 2'd0,
        PH_STATUS = 2'd1,
        PH_XBYTE  = 2'd2,
        PH_YBYTE  = 2'd3
    } phase_t;

    localparam logic signed [9:0] COLS_LIM = 10'(GRID_COLS);
    localparam logic signed [9:0] ROWS_LIM = 10'(GRID_ROWS);
    localparam logic [ps2mct_pkg::COL_W-1:0] COL_MAX = ps2mct_pkg::COL_W'(GRID_COLS - 1);
    localparam logic [ps2mct_pkg::ROW_W-1:0] ROW_MAX = ps2mct_pkg::ROW_W'(GRID_ROWS - 1);
    localparam logic [11:0] COLS_MUL = 12'(GRID_COLS);

    phase_t                              phase_reg;
    phase_t                              phase_next;
    logic [ps2mct_pkg::BYTE_W-1:0]       status_reg;
    logic [ps2mct_pkg::BYTE_W-1:0]       xbyte_reg;
    logic                                prev_left_reg;
    logic [ps2mct_pkg::COL_W-1:0]        col_reg;
    logic [ps2mct_pkg::ROW_W-1:0]        row_reg;
    logic [ps2mct_pkg::CELL_W-1:0]       anchor_reg;
    logic [ps2mct_pkg::CELL_W-1:0]       anchor_next;

    logic signed [ps2mct_pkg::DELTA_W-1:0] dx;
    logic signed [ps2mct_pkg::DELTA_W-1:0] dy;
    logic signed [9:0]                   col_sum;
    logic signed [9:0]                   row_sum;
    logic [ps2mct_pkg::COL_W-1:0]        new_col;
    logic [ps2mct_pkg::ROW_W-1:0]        new_row;
    logic [ps2mct_pkg::CELL_W-1:0]       old_cell;
    logic [ps2mct_pkg::CELL_W-1:0]       new_cell;
    ps2mct_pkg::button_event_t           ev;
    logic                                click;
    logic                                left;

    // Only the Y byte needs room in the result register
    assign take      = item.valid && ((phase_reg != PH_YBYTE) || out_free);
    assign res_valid = take && (phase_reg == PH_YBYTE);

    // Scale deltas; Y is inverted
    assign dx      = ps2mct_pkg::delta_div4(xbyte_reg);
    assign dy      = ps2mct_pkg::delta_div4(item.data);
    assign col_sum = $signed({3'b0, col_reg}) + $signed({{4{dx[5]}}, dx});
    assign row_sum = $signed({5'b0, row_reg}) - $signed({{4{dy[5]}}, dy});

    // Clamp to the grid
    always_comb begin
        if (col_sum >= COLS_LIM) begin
            new_col = COL_MAX;
        end else if (col_sum[9]) begin
            new_col = '0;
        end else begin
            new_col = col_sum[ps2mct_pkg::COL_W-1:0];
        end
        if (row_sum >= ROWS_LIM) begin
            new_row = ROW_MAX;
        end else if (row_sum[9]) begin
            new_row = '0;
        end else begin
            new_row = row_sum[ps2mct_pkg::ROW_W-1:0];
        end
    end

    // Linear cell indices, kept modulo the cell width
    assign old_cell = ps2mct_pkg::CELL_W'(({7'b0, row_reg} * COLS_MUL) + {5'b0, col_reg});
    assign new_cell = ps2mct_pkg::CELL_W'(({7'b0, new_row} * COLS_MUL) + {5'b0, new_col});

    // Classify the left button transition
    assign left = status_reg[0];
    always_comb begin
        anchor_next = anchor_reg;
        click       = 1'b0;
        case ({left, prev_left_reg})
            2'b10: begin
                ev          = ps2mct_pkg::EV_PRESS;
                anchor_next = new_cell;
            end
            2'b11: begin
                ev = ps2mct_pkg::EV_DRAG;
            end
            2'b01: begin
                ev    = ps2mct_pkg::EV_RELEASE;
                click = (anchor_reg == new_cell);
            end
            default: begin
                ev = ps2mct_pkg::EV_HOVER;
            end
        endcase
    end

    // Advance the byte phase
    always_comb begin
        unique case (phase_reg)
            PH_UNSYNC: phase_next = PH_STATUS;
            PH_STATUS: phase_next = PH_XBYTE;
            PH_XBYTE:  phase_next = PH_YBYTE;
            PH_YBYTE:  phase_next = PH_STATUS;
            default:   phase_next = PH_UNSYNC;
        endcase
    end

    // Phase and tracker state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_UNSYNC;
            status_reg    <= '0;
            xbyte_reg     <= '0;
            prev_left_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            anchor_reg    <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            unique case (phase_reg)
                PH_STATUS: begin
                    prev_left_reg <= status_reg[0];
                    status_reg    <= item.data;
                end
                PH_XBYTE: begin
                    xbyte_reg <= item.data;
                end
                PH_YBYTE: begin
                    col_reg    <= new_col;
                    row_reg    <= new_row;
                    anchor_reg <= anchor_next;
                end
                default: begin
                end
            endcase
        end
    end

    assign res.cursor_col   = new_col;
    assign res.cursor_row   = new_row;
    assign res.old_cell     = old_cell;
    assign res.new_cell     = new_cell;
    assign res.left_pressed = left;
    assign res.button_event = ev;
    assign res.anchor_cell  = anchor_next;
    assign res.click        = click;

endmodule

FILE: hdl/ps2mct_out_stage.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker result register
// Holds one decoded packet until the receiver takes it.
// ----------------------------------------------------------------------------
module ps2mct_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                res_valid,
    input  ps2mct_pkg::result_t res,
    output logic                out_free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output ps2mct_pkg::result_t m_res
);

    logic                valid_reg;
    logic                valid_next;
    ps2mct_pkg::result_t res_reg;

    // Room when empty or being taken this cycle
    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

FILE: test/ps2_mouse_cursor_tracker_checker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker checker
// Watches both stream channels of the cursor tracker. Every accepted mouse
// byte runs through a local packet decoder; each Y byte queues the expected
// packet record. Results from the block are compared field by field against
// the oldest queued record, and every mismatch is counted.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ps2_mouse_cursor_tracker_checker
    import ps2mct_pkg::*;
#(
    parameter int GRID_COLS = 80,
    parameter int GRID_ROWS = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,    // [6:0] cursor_col, [11:7] cursor_row,
                                    // [22:12] old_cell, [33:23] new_cell,
                                    // [34] left_pressed, [36:35] button_event,
                                    // [47:37] anchor_cell, [48] click,
                                    // [55:49] zero
    output int          mismatches,
    output int          outstanding
);

    // Position of the next byte within a mouse packet
    typedef enum logic [1:0] {
        PH_UNSYNCED,
        PH_STATUS,
        PH_X,
        PH_Y
    } byte_phase_t;

    byte_phase_t        phase;
    logic [BYTE_W-1:0]  status_q;
    logic [BYTE_W-1:0]  x_byte_q;
    logic               prev_left_q;
    logic [COL_W-1:0]   col_q;
    logic [ROW_W-1:0]   row_q;
    logic [CELL_W-1:0]  anchor_q;
    result_t            expected_packets[$];
    int                 packet_no;

    initial begin
        mismatches  = 0;
        outstanding = 0;
        packet_no   = 0;
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string msg);
        $display("[%0t] packet %0d: %s", $realtime, packet_no, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
        end
    endtask

    function automatic logic [CELL_W-1:0] cell_index(input int r, input int c);
        int lin;
        lin = r * GRID_COLS + c;
        return lin[CELL_W-1:0];
    endfunction

    function automatic int clamp_grid(input int v, input int lim);
        if (v >= lim) begin
            v = lim - 1;
        end
        if (v < 0) begin
            v = 0;
        end
        return v;
    endfunction

    // Advance the packet decoder by one byte; queue a record on each Y byte
    task automatic track_mouse_byte(input logic [BYTE_W-1:0] b);
        int      dx;
        int      dy;
        int      ncol;
        int      nrow;
        result_t r;
        case (phase)
            PH_UNSYNCED: begin
                phase = PH_STATUS;
            end
            PH_STATUS: begin
                prev_left_q = status_q[0];
                status_q    = b;
                phase       = PH_X;
            end
            PH_X: begin
                x_byte_q = b;
                phase    = PH_Y;
            end
            default: begin
                phase = PH_STATUS;
                dx    = int'($signed(x_byte_q));
                dy    = int'($signed(b));
                // integer division truncates toward zero; Y points up
                ncol  = clamp_grid(int'(col_q) + dx / 4, GRID_COLS);
                nrow  = clamp_grid(int'(row_q) - dy / 4, GRID_ROWS);
                r.old_cell     = cell_index(int'(row_q), int'(col_q));
                r.new_cell     = cell_index(nrow, ncol);
                r.left_pressed = status_q[0];
                r.click        = 1'b0;
                if (status_q[0]) begin
                    if (!prev_left_q) begin
                        r.button_event = EV_PRESS;
                        anchor_q       = r.new_cell;
                    end else begin
                        r.button_event = EV_DRAG;
                    end
                end else if (prev_left_q) begin
                    r.button_event = EV_RELEASE;
                    r.click        = (anchor_q == r.new_cell);
                end else begin
                    r.button_event = EV_HOVER;
                end
                r.anchor_cell = anchor_q;
                col_q         = ncol[COL_W-1:0];
                row_q         = nrow[ROW_W-1:0];
                r.cursor_col  = col_q;
                r.cursor_row  = row_q;
                expected_packets.push_back(r);
            end
        endcase
    endtask

    // Sample both channels at each edge: results first, then the new byte
    always @(posedge aclk) begin : watch
        result_t got;
        result_t want;
        if (!aresetn) begin
            phase       = PH_UNSYNCED;
            status_q    = '0;
            x_byte_q    = '0;
            prev_left_q = 1'b0;
            col_q       = '0;
            row_q       = '0;
            anchor_q    = '0;
            expected_packets.delete();
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                packet_no++;
                got = result_t'(m_tdata[48:0]);
                if (expected_packets.size() == 0) begin
                    report_mismatch("result with no packet outstanding");
                end else begin
                    want = expected_packets.pop_front();
                    check_field("cursor_col", 32'(got.cursor_col),
                                32'(want.cursor_col));
                    check_field("cursor_row", 32'(got.cursor_row),
                                32'(want.cursor_row));
                    check_field("old_cell", 32'(got.old_cell), 32'(want.old_cell));
                    check_field("new_cell", 32'(got.new_cell), 32'(want.new_cell));
                    check_field("left_pressed", 32'(got.left_pressed),
                                32'(want.left_pressed));
                    check_field("button_event", 32'(got.button_event),
                                32'(want.button_event));
                    check_field("anchor_cell", 32'(got.anchor_cell),
                                32'(want.anchor_cell));
                    check_field("click", 32'(got.click), 32'(want.click));
                    check_field("padding", 32'(m_tdata[55:49]), 32'd0);
                end
            end
            if (s_tvalid && s_tready) begin
                track_mouse_byte(s_tdata);
            end
            outstanding <= expected_packets.size();
        end
    end

endmodule

FILE: test/tb_ps2_mouse_cursor_tracker_unit.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker testbench
// Feeds the tracker a dropped sync byte, a directed set of packets that hit
// the grid edges, delta extremes and every button transition including a
// click, then random packets with random gaps on both channels. A separate
// checker predicts and compares; this module drives stimulus and reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ps2_mouse_cursor_tracker_unit;
    import ps2mct_pkg::*;

    localparam int GRID_COLS   = 80;
    localparam int GRID_ROWS   = 25;
    localparam int ITEM_TARGET = 1900;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    int          mismatches;
    int          outstanding;
    int          bytes_sent;
    bit          send_burst;
    bit          take_burst;

    ps2_mouse_cursor_tracker_unit #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ps2_mouse_cursor_tracker_checker #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) packet_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Give up well past the slowest legal run
    initial begin
        #2000000;
        $display("ps2_mouse_cursor_tracker_unit: mismatch");
        $finish;
    end

    // Result side: random stalls before taking each item, with bursts
    initial begin : receiver
        int stall;
        m_tready   <= 1'b0;
        take_burst = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                take_burst = !take_burst;
            end
            stall = take_burst ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Offer one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            send_burst = !send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_packet(input logic [7:0] status, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_byte(status);
        send_byte(dx);
        send_byte(dy);
    endtask

    // Hold off the sender until every queued packet has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Random status byte with the left button bit forced
    function automatic logic [7:0] status_with(input logic left);
        logic [7:0] s;
        s    = 8'($urandom_range(0, 255));
        s[0] = left;
        return s;
    endfunction

    // Mix of full-range, small, extreme and large-magnitude deltas
    function automatic logic [7:0] pick_delta();
        logic [7:0] d;
        case ($urandom_range(0, 3))
            0: begin
                d = 8'($urandom_range(0, 255));
            end
            1: begin
                d = 8'(int'($urandom_range(0, 24)) - 12);
            end
            2: begin
                case ($urandom_range(0, 5))
                    0: d = 8'h7F;
                    1: d = 8'h80;
                    2: d = 8'h81;
                    3: d = 8'hFF;
                    4: d = 8'h00;
                    default: d = 8'h01;
                endcase
            end
            default: begin
                d = 8'($urandom_range(64, 127));
                if ($urandom_range(0, 1) != 0) begin
                    d = -d;
                end
            end
        endcase
        return d;
    endfunction

    initial begin : stimulus
        int         packets;
        logic [7:0] tiny_x;
        logic [7:0] tiny_y;
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= 8'h00;
        bytes_sent = 0;
        send_burst = 1'b0;
        packets    = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Sync byte, dropped by the block
        send_byte(8'h5A);
        // Hover right by 31, down past the bottom edge
        send_packet(8'h08, 8'h7F, 8'h80);
        // Press, right again, up past the top edge
        send_packet(8'h09, 8'h7F, 8'h7F);
        // Drag with all upper status bits set, clamp at the right edge
        send_packet(8'hF9, 8'h7F, 8'h00);
        // Release away from the anchor: no click
        send_packet(8'hC8, 8'h00, 8'h00);
        // Press at the most negative X; Y of -1 rounds to no move
        send_packet(8'h01, 8'h80, 8'hFF);
        // Release with deltas that truncate to zero: click on the anchor
        send_packet(8'h00, 8'h03, 8'hFD);
        // Hover left by 32, up by one at the top edge
        send_packet(8'h00, 8'h80, 8'h04);
        // Hover with sign bits set, clamp at the left and bottom edges
        send_packet(8'h06, 8'h81, 8'h81);
        drain_results();

        // Random packets, with press-and-release sequences to reach clicks
        while (bytes_sent < ITEM_TARGET) begin
            if (packets % 150 == 149) begin
                drain_results();
            end
            if ($urandom_range(0, 5) == 0) begin
                tiny_x = 8'(int'($urandom_range(0, 6)) - 3);
                tiny_y = 8'(int'($urandom_range(0, 6)) - 3);
                send_packet(status_with(1'b0), pick_delta(), pick_delta());
                send_packet(status_with(1'b1), pick_delta(), pick_delta());
                send_packet(status_with(1'b0), tiny_x, tiny_y);
                packets += 3;
            end else begin
                send_packet(status_with(1'($urandom_range(0, 1))), pick_delta(),
                            pick_delta());
                packets++;
            end
        end
        drain_results();
        repeat (8) @(posedge aclk);

        if (mismatches == 0) begin
            $display("ps2_mouse_cursor_tracker_unit: match");
        end else begin
            $display("ps2_mouse_cursor_tracker_unit: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/ps2mct_pkg.sv
hdl/ps2mct_in_stage.sv
hdl/ps2mct_cursor_core.sv
hdl/ps2mct_out_stage.sv
hdl/ps2_mouse_cursor_tracker_unit.sv
test/ps2_mouse_cursor_tracker_checker.sv
test/tb_ps2_mouse_cursor_tracker_unit.sv
